FILE: hdl/eight_bit_alu_with_flags_core_macros.svh
// assertion macros used by the alu core top level
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_CORE_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_CORE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define ALU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while in reset
`define ALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ealu_pkg.sv
// shared types, operation codes and flag positions of the alu core
package ealu_pkg;

    // operation codes
    localparam logic [4:0] KIND_ADD   = 5'd0;
    localparam logic [4:0] KIND_ADC   = 5'd1;
    localparam logic [4:0] KIND_SUB   = 5'd2;
    localparam logic [4:0] KIND_SBC   = 5'd3;
    localparam logic [4:0] KIND_AND   = 5'd4;
    localparam logic [4:0] KIND_XOR   = 5'd5;
    localparam logic [4:0] KIND_OR    = 5'd6;
    localparam logic [4:0] KIND_CP    = 5'd7;
    localparam logic [4:0] KIND_INC   = 5'd8;
    localparam logic [4:0] KIND_DEC   = 5'd9;
    localparam logic [4:0] KIND_RLC   = 5'd10;
    localparam logic [4:0] KIND_RRC   = 5'd11;
    localparam logic [4:0] KIND_RL    = 5'd12;
    localparam logic [4:0] KIND_RR    = 5'd13;
    localparam logic [4:0] KIND_SLA   = 5'd14;
    localparam logic [4:0] KIND_SRA   = 5'd15;
    localparam logic [4:0] KIND_SRL   = 5'd16;
    localparam logic [4:0] KIND_SWAP  = 5'd17;
    localparam logic [4:0] KIND_BIT   = 5'd18;
    localparam logic [4:0] KIND_SET   = 5'd19;
    localparam logic [4:0] KIND_RES   = 5'd20;
    localparam logic [4:0] KIND_ADD16 = 5'd21;

    // flag bit positions in the flag byte
    localparam int FLAG_Z = 7;
    localparam int FLAG_N = 6;
    localparam int FLAG_H = 5;
    localparam int FLAG_C = 4;

    // input transaction
    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  accumulator;
        logic [7:0]  operand;
        logic [7:0]  flags_in;
        logic [2:0]  bit_index;
        logic [15:0] wide_left;
        logic [15:0] wide_right;
    } t_alu_in;

    // result transaction
    typedef struct packed {
        logic [7:0]  result;
        logic [15:0] wide_result;
        logic [7:0]  flags_out;
    } t_alu_out;

endpackage

FILE: hdl/ealu_exec.sv
// combinational datapath: byte operations, 16-bit add and flag generation
module ealu_exec (
    input  ealu_pkg::t_alu_in  i_item,
    output ealu_pkg::t_alu_out o_res
);
    import ealu_pkg::*;

    logic [7:0]  a;
    logic [7:0]  r;
    logic [2:0]  idx;
    logic        c_in;
    logic        add_cin;
    logic        sub_cin;
    logic [8:0]  add_sum;
    logic [8:0]  sub_diff;
    logic [16:0] wide_sum;
    logic [7:0]  bit_mask;
    logic [7:0]  res;
    logic [15:0] wide;
    logic        fz;
    logic        fn;
    logic        fh;
    logic        fc;

    assign a    = i_item.accumulator;
    assign r    = i_item.operand;
    assign idx  = i_item.bit_index;
    assign c_in = i_item.flags_in[FLAG_C];

    // carry in only for the with-carry forms
    assign add_cin = (i_item.kind == KIND_ADC) ? c_in : 1'b0;
    assign sub_cin = (i_item.kind == KIND_SBC) ? c_in : 1'b0;

    // shared adders; bit 8 of the difference is the borrow
    assign add_sum  = {1'b0, a} + {1'b0, r} + {8'd0, add_cin};
    assign sub_diff = {1'b0, a} - {1'b0, r} - {8'd0, sub_cin};
    assign wide_sum = {1'b0, i_item.wide_left} + {1'b0, i_item.wide_right};
    assign bit_mask = 8'd1 << idx;

    // operation select and flag rules
    always_comb begin
        res  = 8'd0;
        wide = 16'd0;
        fz   = i_item.flags_in[FLAG_Z];
        fn   = i_item.flags_in[FLAG_N];
        fh   = i_item.flags_in[FLAG_H];
        fc   = c_in;
        unique case (i_item.kind)
            KIND_ADD, KIND_ADC: begin
                res = add_sum[7:0];
                fz  = (add_sum[7:0] == 8'd0);
                fn  = 1'b0;
                fh  = a[4] ^ r[4] ^ add_sum[4];
                fc  = add_sum[8];
            end
            KIND_SUB, KIND_SBC, KIND_CP: begin
                res = (i_item.kind == KIND_CP) ? a : sub_diff[7:0];
                fz  = (sub_diff[7:0] == 8'd0);
                fn  = 1'b1;
                fh  = a[4] ^ r[4] ^ sub_diff[4];
                fc  = sub_diff[8];
            end
            KIND_AND: begin
                res = a & r;
                fz  = ((a & r) == 8'd0);
                fn  = 1'b0;
                fh  = 1'b1;
                fc  = 1'b0;
            end
            KIND_XOR: begin
                res = a ^ r;
                fz  = ((a ^ r) == 8'd0);
                fn  = 1'b0;
                fh  = 1'b0;
                fc  = 1'b0;
            end
            KIND_OR: begin
                res = a | r;
                fz  = ((a | r) == 8'd0);
                fn  = 1'b0;
                fh  = 1'b0;
                fc  = 1'b0;
            end
            KIND_INC: begin
                res = r + 8'd1;
                fz  = (r == 8'hFF);
                fn  = 1'b0;
                fh  = (r[3:0] == 4'hF);
            end
            KIND_DEC: begin
                res = r - 8'd1;
                fz  = (r == 8'd1);
                fn  = 1'b1;
                fh  = (r[3:0] == 4'h0);
            end
            KIND_RLC: begin
                res = {r[6:0], r[7]};
                fz  = (r == 8'd0);
                fn  = 1'b0;
                fh  = 1'b0;
                fc  = r[7];
            end
            KIND_RRC: begin
                res = {r[0], r[7:1]};
                fz  = (r == 8'd0);
                fn  = 1'b0;
                fh  = 1'b0;
                fc  = r[0];
            end
            KIND_RL: begin
                res = {r[6:0], c_in};
                fz  = ({r[6:0], c_in} == 8'd0);
                fn  = 1'b0;
                fh  = 1'b0;
                fc  = r[7];
            end
            KIND_RR: begin
                res = {c_in, r[7:1]};
                fz  = ({c_in, r[7:1]} == 8'd0);
                fn  = 1'b0;
                fh  = 1'b0;
                fc  = r[0];
            end
            KIND_SLA: begin
                res = {r[6:0], 1'b0};
                fz  = (r[6:0] == 7'd0);
                fn  = 1'b0;
                fh  = 1'b0;
                fc  = r[7];
            end
            KIND_SRA: begin
                res = {r[7], r[7:1]};
                fz  = (r[7:1] == 7'd0);
                fn  = 1'b0;
                fh  = 1'b0;
                fc  = r[0];
            end
            KIND_SRL: begin
                res = {1'b0, r[7:1]};
                fz  = (r[7:1] == 7'd0);
                fn  = 1'b0;
                fh  = 1'b0;
                fc  = r[0];
            end
            KIND_SWAP: begin
                res = {r[3:0], r[7:4]};
                fz  = (r == 8'd0);
                fn  = 1'b0;
                fh  = 1'b0;
                fc  = 1'b0;
            end
            KIND_BIT: begin
                res = r;
                fz  = ~r[idx];
                fn  = 1'b0;
                fh  = 1'b1;
            end
            KIND_SET: begin
                res = r | bit_mask;
            end
            KIND_RES: begin
                res = r & ~bit_mask;
            end
            KIND_ADD16: begin
                wide = wide_sum[15:0];
                fn   = 1'b0;
                fh   = i_item.wide_left[12] ^ i_item.wide_right[12] ^ wide_sum[12];
                fc   = wide_sum[16];
            end
            default: begin
                // unused codes: zero result, flags passed through
                res  = 8'd0;
            end
        endcase
    end

    assign o_res.result      = res;
    assign o_res.wide_result = wide;
    assign o_res.flags_out   = {fz, fn, fh, fc, 4'b0000};

endmodule

FILE: hdl/eight_bit_alu_with_flags_core.sv
// alu core top level: input register, datapath and result register
// path: input register, datapath, then result register; the result strobe is high while the result
// register holds the transaction's result, and that result is taken at the edge that ends that cycle
// throughput: one transaction per cycle, busy stays low, set by the single datapath pass
// reset: synchronous active-low reset clears both stage valid flags
// payload registers are not reset; results cannot be held off by the receiver
module eight_bit_alu_with_flags_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ealu_pkg::t_alu_in  i_item,
    output logic               o_res_valid,
    output ealu_pkg::t_alu_out o_res
);
    import ealu_pkg::*;

    logic     r_in_valid;
    t_alu_in  r_in;
    logic     r_out_valid;
    t_alu_out r_out;
    t_alu_out n_out;

    // never stalls: a new transaction is taken every cycle
    assign busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    // datapath
    ealu_exec u_exec (
        .i_item (r_in),
        .o_res  (n_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

`include "eight_bit_alu_with_flags_core_macros.svh"

    // each accepted transaction reaches the input stage and then the result stage
    `ALU_ASSERT_NEXT(a_in_stage, start && !busy, r_in_valid, "accepted transaction lost")
    `ALU_ASSERT_NEXT(a_out_stage, r_in_valid, o_res_valid, "result strobe missing")
    // low nibble of the flag byte is always clear
    `ALU_ASSERT_NOW(a_flag_nibble, o_res_valid, o_res.flags_out[3:0] == 4'd0, "flag low nibble set")
    // only the 16-bit add produces a wide result
    `ALU_ASSERT_NEXT(a_wide_zero, r_in_valid && r_in.kind != KIND_ADD16, o_res.wide_result == 16'd0, "wide result not zero")

endmodule
